// ----- hdl/urbx_pkg.sv -----
// Shared types and constants for the dual-channel serial ring buffer block
// with XON/XOFF flow control. Used by urbx_ctrl, urbx_dp and the top level.
// No dependencies.
`default_nettype none

package urbx_pkg;

    localparam int CHANNELS_DEF = 2;
    localparam int RX_DEPTH_DEF = 64;
    localparam int TX_DEPTH_DEF = 64;

    localparam int BYTE_W      = 8;
    localparam int HIGH_MARK_W = 7;
    localparam int LOW_MARK_W  = 6;
    localparam int LEVEL_W     = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [HIGH_MARK_W-1:0] HIGH_MARK_RST = 7'd48;
    localparam logic [LOW_MARK_W-1:0]  LOW_MARK_RST  = 6'd16;

    // control characters: DC3 pauses, DC1 resumes
    localparam logic [BYTE_W-1:0] XOFF_BYTE = 8'h13;
    localparam logic [BYTE_W-1:0] XON_BYTE  = 8'h11;
    localparam logic [BYTE_W-1:0] CTRL_NONE = 8'h00;

    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_MARK = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_MARK  = 1'b1;

    typedef enum logic [2:0] {
        CMD_LINE_RX    = 3'd0,
        CMD_TX_READY   = 3'd1,
        CMD_HOST_READ  = 3'd2,
        CMD_HOST_WRITE = 3'd3,
        CMD_INIT       = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the beat and launch the ring reads
        logic execute;   // update the channel and load the result
    } dp_cmd_t;

endpackage : urbx_pkg

`default_nettype wire

// ----- hdl/uart_ring_buffers_xon_xoff_top.sv -----
// Top level of the serial ring buffer block with XON/XOFF flow control.
// Depends on urbx_pkg, urbx_ctrl and urbx_dp.
`default_nettype none

// One command beat is taken when start is high and busy is low. Each beat
// has a capture cycle, which reads the addressed channel's receive and
// transmit rings at their tails into registers, and an execute cycle (busy
// high), which updates pointers, fills and flags and writes a stored byte
// back. The result beat appears on the result ports in the cycle after the
// execute cycle, marked by done, which is high for exactly one cycle; a new command may
// be given in that same cycle, but not while a beat executes. The receiver
// cannot hold results off and must take each done beat as it comes. The mark
// registers are written through cfg_wr_en, cfg_addr and cfg_wdata; the user
// must write them only while no command is in flight: the block does not check.
module uart_ring_buffers_xon_xoff_top #(
    parameter int CHANNELS = urbx_pkg::CHANNELS_DEF,
    parameter int RX_DEPTH = urbx_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = urbx_pkg::TX_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [urbx_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [urbx_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [2:0]                         cmd,
    input  wire logic                               channel,
    input  wire logic [urbx_pkg::BYTE_W-1:0]        data_byte,
    input  wire logic                               rx_ok,
    output logic                                    done,
    output logic                                    line_valid,
    output logic [urbx_pkg::BYTE_W-1:0]             line_byte,
    output logic                                    read_valid,
    output logic [urbx_pkg::BYTE_W-1:0]             read_byte,
    output logic                                    write_accepted,
    output logic                                    tx_irq_enable,
    output logic [urbx_pkg::LEVEL_W-1:0]            rx_level,
    output logic [urbx_pkg::LEVEL_W-1:0]            tx_level
);
    import urbx_pkg::*;

    dp_cmd_t dp_cmd;

    urbx_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .dp_cmd (dp_cmd)
    );

    urbx_dp #(
        .CHANNELS (CHANNELS),
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .channel        (channel),
        .data_byte      (data_byte),
        .rx_ok          (rx_ok),
        .line_valid     (line_valid),
        .line_byte      (line_byte),
        .read_valid     (read_valid),
        .read_byte      (read_byte),
        .write_accepted (write_accepted),
        .tx_irq_enable  (tx_irq_enable),
        .rx_level       (rx_level),
        .tx_level       (tx_level)
    );

endmodule : uart_ring_buffers_xon_xoff_top

`default_nettype wire

// ----- hdl/urbx_ctrl.sv -----
// Sequencing state machine for the ring buffer block.
// Depends on urbx_pkg.
`default_nettype none

module urbx_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    output logic                  done,
    output urbx_pkg::dp_cmd_t     dp_cmd
);
    import urbx_pkg::*;

    state_t state_reg, state_next;
    logic   done_reg;

    always_comb
    begin
        dp_cmd.capture = (state_reg == ST_IDLE) && start;
        dp_cmd.execute = (state_reg == ST_EXEC);
        state_next     = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= dp_cmd.execute;
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

    a_done_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(dp_cmd.execute))
        else $error("result strobe without a preceding execute cycle");

    a_exec_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.execute |=> (done && !busy))
        else $error("execute cycle did not end in a result beat");

    a_no_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !dp_cmd.capture)
        else $error("beat captured while busy");

endmodule : urbx_ctrl

`default_nettype wire

// ----- hdl/urbx_dp.sv -----
// Datapath: per-channel ring pointers, fills and flow-control flags, the
// receive and transmit byte memories, mark registers and result registers.
// Depends on urbx_pkg.
`default_nettype none

module urbx_dp #(
    parameter int CHANNELS = urbx_pkg::CHANNELS_DEF,
    parameter int RX_DEPTH = urbx_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = urbx_pkg::TX_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  urbx_pkg::dp_cmd_t                       dp_cmd,
    input  wire logic                               cfg_wr_en,
    input  wire logic [urbx_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [urbx_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic [2:0]                         cmd,
    input  wire logic                               channel,
    input  wire logic [urbx_pkg::BYTE_W-1:0]        data_byte,
    input  wire logic                               rx_ok,
    output logic                                    line_valid,
    output logic [urbx_pkg::BYTE_W-1:0]             line_byte,
    output logic                                    read_valid,
    output logic [urbx_pkg::BYTE_W-1:0]             read_byte,
    output logic                                    write_accepted,
    output logic                                    tx_irq_enable,
    output logic [urbx_pkg::LEVEL_W-1:0]            rx_level,
    output logic [urbx_pkg::LEVEL_W-1:0]            tx_level
);
    import urbx_pkg::*;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RX_PTR_W  = $clog2(RX_DEPTH);
    localparam int TX_PTR_W  = $clog2(TX_DEPTH);
    localparam int RX_FILL_W = $clog2(RX_DEPTH + 1);
    localparam int TX_FILL_W = $clog2(TX_DEPTH + 1);
    localparam int RX_CMP_W  = (RX_FILL_W > HIGH_MARK_W) ? RX_FILL_W : HIGH_MARK_W;

    localparam logic [RX_PTR_W-1:0]  RX_PTR_LAST = RX_PTR_W'(RX_DEPTH - 1);
    localparam logic [TX_PTR_W-1:0]  TX_PTR_LAST = TX_PTR_W'(TX_DEPTH - 1);
    localparam logic [RX_FILL_W-1:0] RX_FULL     = RX_FILL_W'(RX_DEPTH);
    localparam logic [TX_FILL_W-1:0] TX_FULL     = TX_FILL_W'(TX_DEPTH);

    // configuration
    logic [HIGH_MARK_W-1:0] high_mark_reg;
    logic [LOW_MARK_W-1:0]  low_mark_reg;

    // per-channel state
    logic [RX_PTR_W-1:0]  rx_head_reg  [CHANNELS];
    logic [RX_PTR_W-1:0]  rx_tail_reg  [CHANNELS];
    logic [RX_FILL_W-1:0] rx_fill_reg  [CHANNELS];
    logic [TX_PTR_W-1:0]  tx_head_reg  [CHANNELS];
    logic [TX_PTR_W-1:0]  tx_tail_reg  [CHANNELS];
    logic [TX_FILL_W-1:0] tx_fill_reg  [CHANNELS];
    logic                 throttled_reg[CHANNELS];
    logic                 paused_reg   [CHANNELS];
    logic [BYTE_W-1:0]    pending_reg  [CHANNELS];
    logic                 tx_en_reg    [CHANNELS];

    // byte memories
    logic [BYTE_W-1:0] rx_mem [CHANNELS][RX_DEPTH];
    logic [BYTE_W-1:0] tx_mem [CHANNELS][TX_DEPTH];
    logic [BYTE_W-1:0] rx_rd_reg;
    logic [BYTE_W-1:0] tx_rd_reg;

    // captured beat
    cmd_t              cmd_reg;
    logic [CH_W-1:0]   cidx_reg;
    logic              ch_ok_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              ok_reg;

    // results
    logic              line_valid_reg, read_valid_reg, write_acc_reg, tx_irq_reg;
    logic [BYTE_W-1:0] line_byte_reg, read_byte_reg;
    logic [LEVEL_W-1:0] rx_level_reg, tx_level_reg;

    logic              in_ch_ok;
    logic [CH_W-1:0]   in_cidx;

    // working values for the addressed channel
    logic [RX_PTR_W-1:0]  rx_head_next, rx_tail_next;
    logic [RX_FILL_W-1:0] rx_fill_next;
    logic [TX_PTR_W-1:0]  tx_head_next, tx_tail_next;
    logic [TX_FILL_W-1:0] tx_fill_next;
    logic                 throttled_next, paused_next, tx_en_next;
    logic [BYTE_W-1:0]    pending_next;
    logic                 rx_wr, tx_wr;
    logic                 lv, rv, wa;
    logic [BYTE_W-1:0]    lb, rb;

    assign in_ch_ok = (32'(channel) < CHANNELS);
    assign in_cidx  = in_ch_ok ? CH_W'(channel) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_mark_reg <= HIGH_MARK_RST;
            low_mark_reg  <= LOW_MARK_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_HIGH_MARK: high_mark_reg <= cfg_wdata;
                REG_LOW_MARK:  low_mark_reg  <= cfg_wdata[LOW_MARK_W-1:0];
                default:       ;
            endcase
        end
    end

    // capture the beat
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg   <= cmd_t'(cmd);
            cidx_reg  <= in_cidx;
            ch_ok_reg <= in_ch_ok;
            byte_reg  <= data_byte;
            ok_reg    <= rx_ok;
        end
    end

    // ring memories: read at the tails on capture, write back on execute
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            rx_rd_reg <= rx_mem[in_cidx][rx_tail_reg[in_cidx]];
        end
        if (rx_wr)
        begin
            rx_mem[cidx_reg][rx_head_reg[cidx_reg]] <= byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            tx_rd_reg <= tx_mem[in_cidx][tx_tail_reg[in_cidx]];
        end
        if (tx_wr)
        begin
            tx_mem[cidx_reg][tx_head_reg[cidx_reg]] <= byte_reg;
        end
    end

    always_comb
    begin
        rx_head_next   = rx_head_reg[cidx_reg];
        rx_tail_next   = rx_tail_reg[cidx_reg];
        rx_fill_next   = rx_fill_reg[cidx_reg];
        tx_head_next   = tx_head_reg[cidx_reg];
        tx_tail_next   = tx_tail_reg[cidx_reg];
        tx_fill_next   = tx_fill_reg[cidx_reg];
        throttled_next = throttled_reg[cidx_reg];
        paused_next    = paused_reg[cidx_reg];
        pending_next   = pending_reg[cidx_reg];
        tx_en_next     = tx_en_reg[cidx_reg];
        rx_wr          = 1'b0;
        tx_wr          = 1'b0;
        lv             = 1'b0;
        lb             = '0;
        rv             = 1'b0;
        rb             = '0;
        wa             = 1'b0;

        unique case (cmd_reg)
            CMD_LINE_RX:
            begin
                if (ok_reg)
                begin
                    if (byte_reg == XOFF_BYTE)
                    begin
                        paused_next = 1'b1;
                    end
                    else if (byte_reg == XON_BYTE)
                    begin
                        paused_next = 1'b0;
                        tx_en_next  = 1'b1;
                    end
                    else
                    begin
                        rx_wr        = 1'b1;
                        rx_head_next = (rx_head_next == RX_PTR_LAST) ? '0
                                                                     : rx_head_next + 1'b1;
                        // full ring: drop the oldest byte
                        if (rx_fill_next < RX_FULL)
                        begin
                            rx_fill_next = rx_fill_next + 1'b1;
                        end
                        else
                        begin
                            rx_tail_next = (rx_tail_next == RX_PTR_LAST) ? '0
                                                                         : rx_tail_next + 1'b1;
                        end
                        if ((RX_CMP_W'(rx_fill_next) >= RX_CMP_W'(high_mark_reg))
                            && !throttled_next)
                        begin
                            throttled_next = 1'b1;
                            pending_next   = XOFF_BYTE;
                            tx_en_next     = 1'b1;
                        end
                    end
                end
            end
            CMD_TX_READY:
            begin
                if (tx_en_next)
                begin
                    if (pending_next != CTRL_NONE)
                    begin
                        lv           = 1'b1;
                        lb           = pending_next;
                        pending_next = CTRL_NONE;
                    end
                    else if ((tx_fill_next != '0) && !paused_next)
                    begin
                        lv           = 1'b1;
                        lb           = tx_rd_reg;
                        tx_tail_next = (tx_tail_next == TX_PTR_LAST) ? '0
                                                                     : tx_tail_next + 1'b1;
                        tx_fill_next = tx_fill_next - 1'b1;
                    end
                    else
                    begin
                        tx_en_next = 1'b0;
                    end
                end
            end
            CMD_HOST_READ:
            begin
                if (rx_fill_next != '0)
                begin
                    rx_fill_next = rx_fill_next - 1'b1;
                    if ((RX_CMP_W'(rx_fill_next) <= RX_CMP_W'(low_mark_reg))
                        && throttled_next)
                    begin
                        throttled_next = 1'b0;
                        pending_next   = XON_BYTE;
                        tx_en_next     = 1'b1;
                    end
                    rv           = 1'b1;
                    rb           = rx_rd_reg;
                    rx_tail_next = (rx_tail_next == RX_PTR_LAST) ? '0
                                                                 : rx_tail_next + 1'b1;
                end
            end
            CMD_HOST_WRITE:
            begin
                if (tx_fill_next < TX_FULL)
                begin
                    tx_wr        = 1'b1;
                    tx_head_next = (tx_head_next == TX_PTR_LAST) ? '0
                                                                 : tx_head_next + 1'b1;
                    tx_fill_next = tx_fill_next + 1'b1;
                    wa           = 1'b1;
                    if (!paused_next)
                    begin
                        tx_en_next = 1'b1;
                    end
                end
            end
            CMD_INIT:
            begin
                rx_head_next   = '0;
                rx_tail_next   = '0;
                rx_fill_next   = '0;
                tx_head_next   = '0;
                tx_tail_next   = '0;
                tx_fill_next   = '0;
                throttled_next = 1'b0;
                paused_next    = 1'b0;
                pending_next   = CTRL_NONE;
                tx_en_next     = 1'b0;
            end
            default:
            begin
            end
        endcase

        // no write-back outside execute or for an absent channel
        if (!(dp_cmd.execute && ch_ok_reg))
        begin
            rx_wr = 1'b0;
            tx_wr = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                rx_head_reg[c]   <= '0;
                rx_tail_reg[c]   <= '0;
                rx_fill_reg[c]   <= '0;
                tx_head_reg[c]   <= '0;
                tx_tail_reg[c]   <= '0;
                tx_fill_reg[c]   <= '0;
                throttled_reg[c] <= 1'b0;
                paused_reg[c]    <= 1'b0;
                pending_reg[c]   <= CTRL_NONE;
                tx_en_reg[c]     <= 1'b0;
            end
        end
        else if (dp_cmd.execute && ch_ok_reg)
        begin
            rx_head_reg[cidx_reg]   <= rx_head_next;
            rx_tail_reg[cidx_reg]   <= rx_tail_next;
            rx_fill_reg[cidx_reg]   <= rx_fill_next;
            tx_head_reg[cidx_reg]   <= tx_head_next;
            tx_tail_reg[cidx_reg]   <= tx_tail_next;
            tx_fill_reg[cidx_reg]   <= tx_fill_next;
            throttled_reg[cidx_reg] <= throttled_next;
            paused_reg[cidx_reg]    <= paused_next;
            pending_reg[cidx_reg]   <= pending_next;
            tx_en_reg[cidx_reg]     <= tx_en_next;
        end
    end

    // result beat: all zero for an absent channel
    always_ff @(posedge clk)
    begin
        if (dp_cmd.execute)
        begin
            line_valid_reg <= ch_ok_reg & lv;
            line_byte_reg  <= ch_ok_reg ? lb : '0;
            read_valid_reg <= ch_ok_reg & rv;
            read_byte_reg  <= ch_ok_reg ? rb : '0;
            write_acc_reg  <= ch_ok_reg & wa;
            tx_irq_reg     <= ch_ok_reg & tx_en_next;
            rx_level_reg   <= ch_ok_reg ? LEVEL_W'(rx_fill_next) : '0;
            tx_level_reg   <= ch_ok_reg ? LEVEL_W'(tx_fill_next) : '0;
        end
    end

    assign line_valid     = line_valid_reg;
    assign line_byte      = line_byte_reg;
    assign read_valid     = read_valid_reg;
    assign read_byte      = read_byte_reg;
    assign write_accepted = write_acc_reg;
    assign tx_irq_enable  = tx_irq_reg;
    assign rx_level       = rx_level_reg;
    assign tx_level       = tx_level_reg;

    a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.execute |-> (rx_fill_reg[cidx_reg] <= RX_FULL)
                        && (tx_fill_reg[cidx_reg] <= TX_FULL))
        else $error("ring fill beyond depth");

    a_pending_code: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.execute |-> (pending_reg[cidx_reg] == CTRL_NONE)
                        || (pending_reg[cidx_reg] == XON_BYTE)
                        || (pending_reg[cidx_reg] == XOFF_BYTE))
        else $error("pending control byte is neither XON nor XOFF");

endmodule : urbx_dp

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking bench for uart_ring_buffers_xon_xoff_top: a behavioural copy of the
// rings and the XON/XOFF flags predicts every result beat, and a monitor checks each one.
// Depends on urbx_pkg and the RTL under hdl/.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import urbx_pkg::*;

    localparam int RING_DEPTH     = RX_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;

    // command codes the block does not decode
    localparam logic [2:0] CMD_SPARE5 = 3'd5;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic                line_valid;
        logic [BYTE_W-1:0]   line_byte;
        logic                read_valid;
        logic [BYTE_W-1:0]   read_byte;
        logic                write_accepted;
        logic                tx_irq_enable;
        logic [LEVEL_W-1:0]  rx_level;
        logic [LEVEL_W-1:0]  tx_level;
    } serial_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr = REG_HIGH_MARK;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [2:0]              cmd = CMD_LINE_RX;
    logic                    channel = 1'b0;
    logic [BYTE_W-1:0]       data_byte = '0;
    logic                    rx_ok = 1'b0;
    logic                    done;
    logic                    line_valid;
    logic [BYTE_W-1:0]       line_byte;
    logic                    read_valid;
    logic [BYTE_W-1:0]       read_byte;
    logic                    write_accepted;
    logic                    tx_irq_enable;
    logic [LEVEL_W-1:0]      rx_level;
    logic [LEVEL_W-1:0]      tx_level;

    uart_ring_buffers_xon_xoff_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .channel        (channel),
        .data_byte      (data_byte),
        .rx_ok          (rx_ok),
        .done           (done),
        .line_valid     (line_valid),
        .line_byte      (line_byte),
        .read_valid     (read_valid),
        .read_byte      (read_byte),
        .write_accepted (write_accepted),
        .tx_irq_enable  (tx_irq_enable),
        .rx_level       (rx_level),
        .tx_level       (tx_level)
    );

    always #5 clk = ~clk;

    // predicted channel state
    bit [BYTE_W-1:0]      rx_ring [2][RING_DEPTH];
    bit [BYTE_W-1:0]      tx_ring [2][RING_DEPTH];
    bit [5:0]             rx_wr_ptr [2];
    bit [5:0]             rx_rd_ptr [2];
    bit [LEVEL_W-1:0]     rx_count [2];
    bit [5:0]             tx_wr_ptr [2];
    bit [5:0]             tx_rd_ptr [2];
    bit [LEVEL_W-1:0]     tx_count [2];
    bit                   throttled [2];
    bit                   paused [2];
    bit [BYTE_W-1:0]      ctrl_queued [2];
    bit                   tx_en [2];
    bit [HIGH_MARK_W-1:0] xoff_level = HIGH_MARK_RST;
    bit [LOW_MARK_W-1:0]  xon_level = LOW_MARK_RST;

    serial_result_t awaited_results [$];
    int errors = 0;
    int quiet_cycles = 0;
    bit gaps_on = 1'b1;

    function automatic void wipe_channel(input logic ch);
        rx_wr_ptr[ch] = '0;
        rx_rd_ptr[ch] = '0;
        rx_count[ch] = '0;
        tx_wr_ptr[ch] = '0;
        tx_rd_ptr[ch] = '0;
        tx_count[ch] = '0;
        throttled[ch] = 1'b0;
        paused[ch] = 1'b0;
        ctrl_queued[ch] = CTRL_NONE;
        tx_en[ch] = 1'b0;
    endfunction

    function automatic serial_result_t ring_step(input logic [2:0] c, input logic ch,
                                                 input logic [BYTE_W-1:0] d, input logic ok);
        serial_result_t r;
        r = '0;
        case (c)
            CMD_LINE_RX:
            begin
                if (ok)
                begin
                    if (d == XOFF_BYTE)
                    begin
                        paused[ch] = 1'b1;
                    end
                    else if (d == XON_BYTE)
                    begin
                        paused[ch] = 1'b0;
                        tx_en[ch] = 1'b1;
                    end
                    else
                    begin
                        rx_ring[ch][rx_wr_ptr[ch]] = d;
                        rx_wr_ptr[ch] = rx_wr_ptr[ch] + 6'd1;
                        // full ring: drop the oldest byte
                        if (rx_count[ch] < RING_DEPTH)
                            rx_count[ch] = rx_count[ch] + 7'd1;
                        else
                            rx_rd_ptr[ch] = rx_rd_ptr[ch] + 6'd1;
                        if (rx_count[ch] >= xoff_level && !throttled[ch])
                        begin
                            throttled[ch] = 1'b1;
                            ctrl_queued[ch] = XOFF_BYTE;
                            tx_en[ch] = 1'b1;
                        end
                    end
                end
            end
            CMD_TX_READY:
            begin
                if (tx_en[ch])
                begin
                    if (ctrl_queued[ch] != CTRL_NONE)
                    begin
                        r.line_valid = 1'b1;
                        r.line_byte = ctrl_queued[ch];
                        ctrl_queued[ch] = CTRL_NONE;
                    end
                    else if (tx_count[ch] > 0 && !paused[ch])
                    begin
                        r.line_valid = 1'b1;
                        r.line_byte = tx_ring[ch][tx_rd_ptr[ch]];
                        tx_rd_ptr[ch] = tx_rd_ptr[ch] + 6'd1;
                        tx_count[ch] = tx_count[ch] - 7'd1;
                    end
                    else
                    begin
                        tx_en[ch] = 1'b0;
                    end
                end
            end
            CMD_HOST_READ:
            begin
                if (rx_count[ch] > 0)
                begin
                    rx_count[ch] = rx_count[ch] - 7'd1;
                    if (rx_count[ch] <= xon_level && throttled[ch])
                    begin
                        throttled[ch] = 1'b0;
                        ctrl_queued[ch] = XON_BYTE;
                        tx_en[ch] = 1'b1;
                    end
                    r.read_valid = 1'b1;
                    r.read_byte = rx_ring[ch][rx_rd_ptr[ch]];
                    rx_rd_ptr[ch] = rx_rd_ptr[ch] + 6'd1;
                end
            end
            CMD_HOST_WRITE:
            begin
                if (tx_count[ch] < RING_DEPTH)
                begin
                    tx_ring[ch][tx_wr_ptr[ch]] = d;
                    tx_wr_ptr[ch] = tx_wr_ptr[ch] + 6'd1;
                    tx_count[ch] = tx_count[ch] + 7'd1;
                    r.write_accepted = 1'b1;
                    if (!paused[ch])
                        tx_en[ch] = 1'b1;
                end
            end
            CMD_INIT: wipe_channel(ch);
            default: ;
        endcase
        r.tx_irq_enable = tx_en[ch];
        r.rx_level = rx_count[ch];
        r.tx_level = tx_count[ch];
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 255));
        while (b == XON_BYTE || b == XOFF_BYTE)
            b = BYTE_W'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // drive one command beat and hold it until the block takes it
    task automatic send_beat(input logic [2:0] c, input logic ch,
                             input logic [BYTE_W-1:0] d, input logic ok);
        if (gaps_on && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 9));
        start <= 1'b1;
        cmd <= c;
        channel <= ch;
        data_byte <= d;
        rx_ok <= ok;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        awaited_results.push_back(ring_step(c, ch, d, ok));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called with nothing in flight
    task automatic write_marks(input logic [HIGH_MARK_W-1:0] hi, input logic [LOW_MARK_W-1:0] lo);
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_HIGH_MARK;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_addr <= REG_LOW_MARK;
        cfg_wdata <= CFG_DATA_W'(lo);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        xoff_level = hi;
        xon_level = lo;
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_beat(CMD_HOST_READ, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_TX_READY, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_LINE_RX, 1'b0, 8'hff, 1'b0);
        send_beat(CMD_LINE_RX, 1'b0, 8'h00, 1'b1);
        send_beat(CMD_LINE_RX, 1'b0, 8'hff, 1'b1);
        send_beat(CMD_HOST_READ, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_LINE_RX, 1'b0, XOFF_BYTE, 1'b1);
        send_beat(CMD_HOST_WRITE, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_HOST_WRITE, 1'b0, 8'hff, 1'b1);
        send_beat(CMD_TX_READY, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_LINE_RX, 1'b0, XON_BYTE, 1'b1);
        send_beat(CMD_TX_READY, 1'b0, 8'h00, 1'b0);
        // paused with data waiting: the ready event must drop the enable
        send_beat(CMD_LINE_RX, 1'b0, XOFF_BYTE, 1'b1);
        send_beat(CMD_TX_READY, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_LINE_RX, 1'b0, XON_BYTE, 1'b1);
        send_beat(CMD_TX_READY, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_TX_READY, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_HOST_WRITE, 1'b1, 8'h5a, 1'b1);
        send_beat(CMD_SPARE5, 1'b1, 8'hff, 1'b1);
        send_beat(CMD_SPARE6, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_SPARE7, 1'b1, 8'ha5, 1'b1);
        send_beat(CMD_INIT, 1'b1, 8'h00, 1'b0);
        send_beat(CMD_HOST_READ, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_LINE_RX, 1'b1, XON_BYTE, 1'b0);
        send_beat(CMD_INIT, 1'b0, 8'h00, 1'b0);
    endtask

    // overrun the receive ring through XOFF and back to XON, then overfill transmit
    task automatic test_ring_limits();
        repeat (RING_DEPTH + 2) send_beat(CMD_LINE_RX, 1'b0, plain_byte(), 1'b1);
        send_beat(CMD_TX_READY, 1'b0, 8'h00, 1'b0);
        repeat (50) send_beat(CMD_HOST_READ, 1'b0, 8'h00, 1'b0);
        repeat (2) send_beat(CMD_TX_READY, 1'b0, 8'h00, 1'b0);
        repeat (RING_DEPTH + 1)
            send_beat(CMD_HOST_WRITE, 1'b1, BYTE_W'($urandom_range(0, 255)), 1'b1);
        repeat (3) send_beat(CMD_TX_READY, 1'b1, 8'h00, 1'b0);
    endtask

    task automatic run_traffic(input int n_items, input bit idle_ok);
        int sent;
        int mode;
        int len;
        int r;
        int i;
        logic [2:0] c;
        logic ch;
        logic [BYTE_W-1:0] d;
        logic ok;
        sent = 0;
        while (sent < n_items)
        begin
            mode = $urandom_range(0, 4);
            ch = 1'($urandom_range(0, 1));
            len = $urandom_range(8, 80);
            gaps_on = idle_ok && ($urandom_range(0, 2) != 0);
            for (i = 0; i < len && sent < n_items; i++)
            begin
                r = $urandom_range(0, 99);
                d = BYTE_W'($urandom_range(0, 255));
                ok = 1'b1;
                if (r < 10)
                begin
                    c = 3'($urandom_range(0, 7));
                    ok = 1'($urandom_range(0, 1));
                    send_beat(c, 1'($urandom_range(0, 1)), d, ok);
                end
                else
                begin
                    case (mode)
                        0: c = (r < 90) ? CMD_LINE_RX : CMD_TX_READY;
                        1: c = (r < 75) ? CMD_HOST_READ : CMD_TX_READY;
                        2: c = (r < 90) ? CMD_HOST_WRITE : CMD_TX_READY;
                        3: c = (r < 80) ? CMD_TX_READY : CMD_HOST_WRITE;
                        default: c = (r < 13) ? CMD_INIT : 3'($urandom_range(0, 3));
                    endcase
                    if (c == CMD_LINE_RX)
                    begin
                        case ($urandom_range(0, 9))
                            0: d = XOFF_BYTE;
                            1: d = XON_BYTE;
                            default: ;
                        endcase
                        ok = ($urandom_range(0, 19) != 0);
                    end
                    send_beat(c, ch, d, ok);
                end
                sent++;
            end
        end
    endtask

    task automatic test_mark_settings();
        logic [HIGH_MARK_W-1:0] hi_set [6];
        logic [LOW_MARK_W-1:0]  lo_set [6];
        int k;
        hi_set = '{7'd1, 7'd64, 7'd64, 7'd1, 7'd32, HIGH_MARK_RST};
        lo_set = '{6'd0, 6'd63, 6'd0, 6'd63, 6'd8, LOW_MARK_RST};
        hi_set[4] = HIGH_MARK_W'($urandom_range(1, 64));
        lo_set[4] = LOW_MARK_W'($urandom_range(0, 63));
        for (k = 0; k < 6; k++)
        begin
            wait_drained();
            write_marks(hi_set[k], lo_set[k]);
            // last phase runs without sender gaps
            run_traffic(140, k < 5);
        end
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        serial_result_t want;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t result beat with nothing awaited: expected none, actual rx_level %0h",
                         $time, rx_level);
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("line_valid", BYTE_W'(want.line_valid), BYTE_W'(line_valid));
                check_field("line_byte", want.line_byte, line_byte);
                check_field("read_valid", BYTE_W'(want.read_valid), BYTE_W'(read_valid));
                check_field("read_byte", want.read_byte, read_byte);
                check_field("write_accepted", BYTE_W'(want.write_accepted),
                            BYTE_W'(write_accepted));
                check_field("tx_irq_enable", BYTE_W'(want.tx_irq_enable),
                            BYTE_W'(tx_irq_enable));
                check_field("rx_level", BYTE_W'(want.rx_level), BYTE_W'(rx_level));
                check_field("tx_level", BYTE_W'(want.tx_level), BYTE_W'(tx_level));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        wipe_channel(1'b0);
        wipe_channel(1'b1);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gaps_on = 1'b1;
        test_directed();
        test_ring_limits();
        test_mark_settings();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule : tb_top

`default_nettype wire
